[rtl/hpq_pkg.sv]
package hpq_pkg;

  typedef enum logic [1:0] {
    ST_PUSH_OK = 2'd0,
    ST_POP_OK  = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_A,
    S_POP_B,
    S_PU_CHK,
    S_PU_CMP,
    S_SD_L,
    S_SD_R,
    S_SD_RC,
    S_SD_DEC,
    S_FIN
  } state_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int KEY_PORT_W = 32;
  localparam int TAG_PORT_W = 16;
  localparam int OCC_W      = 7;
  localparam int LIMIT_W    = 7;

  typedef struct packed {
    status_t                 status;
    logic [KEY_PORT_W-1:0]   key;
    logic [TAG_PORT_W-1:0]   tag;
    logic [OCC_W-1:0]        occ;
  } res_t;

endpackage

[rtl/hpq_mem.sv]
module hpq_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 48,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/hpq_core.sv]
module hpq_core #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             op,
  input  logic [hpq_pkg::KEY_PORT_W-1:0]   key_in,
  input  logic [hpq_pkg::TAG_PORT_W-1:0]   tag_in,
  input  logic [hpq_pkg::LIMIT_W-1:0]      limit,
  input  logic                             take,
  output logic                             ready,
  output logic                             done,
  output hpq_pkg::res_t                    res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = KEY_WIDTH + TAG_WIDTH;

  hpq_pkg::state_t state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        pos, pos_next;
  logic [KEY_WIDTH-1:0] mv_key, mv_key_next;
  logic [TAG_WIDTH-1:0] mv_tag, mv_tag_next;
  logic [KEY_WIDTH-1:0] ch_key, ch_key_next;
  logic [TAG_WIDTH-1:0] ch_tag, ch_tag_next;
  logic [AW-1:0]        ch_idx, ch_idx_next;
  hpq_pkg::status_t     res_status, res_status_next;
  logic [KEY_WIDTH-1:0] res_key, res_key_next;
  logic [TAG_WIDTH-1:0] res_tag, res_tag_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  logic [KEY_WIDTH-1:0] rd_key;
  logic [TAG_WIDTH-1:0] rd_tag;

  // shared key comparator
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 cmp_lt;

  int unsigned pos_i, cnt_i, lft_i;

  hpq_mem #(
    .DEPTH (DEPTH),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_key = mem_rdata[DW-1:TAG_WIDTH];
  assign rd_tag = mem_rdata[TAG_WIDTH-1:0];
  assign cmp_lt = cmp_a < cmp_b;

  assign pos_i = 32'(pos);
  assign cnt_i = 32'(count);
  assign lft_i = 2 * pos_i + 1;

  assign ready = (state == hpq_pkg::S_IDLE);
  assign done  = (state == hpq_pkg::S_FIN);

  assign res.status = res_status;
  assign res.key    = hpq_pkg::KEY_PORT_W'(res_key);
  assign res.tag    = hpq_pkg::TAG_PORT_W'(res_tag);
  assign res.occ    = hpq_pkg::OCC_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    mv_key     <= mv_key_next;
    mv_tag     <= mv_tag_next;
    ch_key     <= ch_key_next;
    ch_tag     <= ch_tag_next;
    ch_idx     <= ch_idx_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_tag    <= res_tag_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    mv_key_next     = mv_key;
    mv_tag_next     = mv_tag;
    ch_key_next     = ch_key;
    ch_tag_next     = ch_tag;
    ch_idx_next     = ch_idx;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_tag_next    = res_tag;
    mem_we          = 1'b0;
    mem_waddr       = pos;
    mem_wdata       = {mv_key, mv_tag};
    mem_raddr       = '0;
    cmp_a           = mv_key;
    cmp_b           = ch_key;

    case (state)
      hpq_pkg::S_IDLE: begin
        // root read is issued every idle cycle so a pop finds it next cycle
        mem_raddr    = '0;
        res_key_next = '0;
        res_tag_next = '0;
        if (start) begin
          if (op == hpq_pkg::OP_PUSH) begin
            if (cnt_i >= 32'(limit) || cnt_i >= DEPTH) begin
              res_status_next = hpq_pkg::ST_FULL;
              state_next      = hpq_pkg::S_FIN;
            end else begin
              res_status_next = hpq_pkg::ST_PUSH_OK;
              mv_key_next     = KEY_WIDTH'(key_in);
              mv_tag_next     = TAG_WIDTH'(tag_in);
              pos_next        = AW'(count);
              count_next      = count + CW'(1);
              state_next      = hpq_pkg::S_PU_CHK;
            end
          end else begin
            if (count == '0) begin
              res_status_next = hpq_pkg::ST_EMPTY;
              state_next      = hpq_pkg::S_FIN;
            end else begin
              res_status_next = hpq_pkg::ST_POP_OK;
              count_next      = count - CW'(1);
              state_next      = hpq_pkg::S_POP_A;
            end
          end
        end
      end

      hpq_pkg::S_POP_A: begin
        res_key_next = rd_key;
        res_tag_next = rd_tag;
        mem_raddr    = AW'(count);
        state_next   = hpq_pkg::S_POP_B;
      end

      hpq_pkg::S_POP_B: begin
        mv_key_next = rd_key;
        mv_tag_next = rd_tag;
        pos_next    = '0;
        state_next  = (count == '0) ? hpq_pkg::S_FIN : hpq_pkg::S_SD_L;
      end

      hpq_pkg::S_PU_CHK: begin
        mem_raddr = AW'((pos_i - 1) >> 1);
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = hpq_pkg::S_FIN;
        end else begin
          state_next = hpq_pkg::S_PU_CMP;
        end
      end

      hpq_pkg::S_PU_CMP: begin
        cmp_a = rd_key;
        cmp_b = mv_key;
        mem_we = 1'b1;
        if (!cmp_lt) begin
          state_next = hpq_pkg::S_FIN;
        end else begin
          mem_wdata  = mem_rdata;
          pos_next   = AW'((pos_i - 1) >> 1);
          state_next = hpq_pkg::S_PU_CHK;
        end
      end

      hpq_pkg::S_SD_L: begin
        mem_raddr = AW'(lft_i);
        if (lft_i >= cnt_i) begin
          mem_we     = 1'b1;
          state_next = hpq_pkg::S_FIN;
        end else begin
          state_next = hpq_pkg::S_SD_R;
        end
      end

      hpq_pkg::S_SD_R: begin
        ch_key_next = rd_key;
        ch_tag_next = rd_tag;
        ch_idx_next = AW'(lft_i);
        mem_raddr   = AW'(lft_i + 1);
        state_next  = (lft_i + 1 < cnt_i) ? hpq_pkg::S_SD_RC : hpq_pkg::S_SD_DEC;
      end

      hpq_pkg::S_SD_RC: begin
        cmp_a = ch_key;
        cmp_b = rd_key;
        if (cmp_lt) begin
          ch_key_next = rd_key;
          ch_tag_next = rd_tag;
          ch_idx_next = AW'(lft_i + 1);
        end
        state_next = hpq_pkg::S_SD_DEC;
      end

      hpq_pkg::S_SD_DEC: begin
        cmp_a  = mv_key;
        cmp_b  = ch_key;
        mem_we = 1'b1;
        if (!cmp_lt) begin
          state_next = hpq_pkg::S_FIN;
        end else begin
          mem_wdata  = {ch_key, ch_tag};
          pos_next   = ch_idx;
          state_next = hpq_pkg::S_SD_L;
        end
      end

      hpq_pkg::S_FIN: begin
        if (take) begin
          state_next = hpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = hpq_pkg::S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count above depth");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != hpq_pkg::S_IDLE) |=> $stable(count))
    else $error("entry count changed mid operation");

  a_pos_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == hpq_pkg::S_PU_CHK || state == hpq_pkg::S_SD_L) |-> (pos_i < cnt_i))
    else $error("sift position outside heap");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res_status != hpq_pkg::ST_POP_OK) |-> (res_key == '0 && res_tag == '0))
    else $error("non-pop result carries data");

endmodule

[rtl/binary_max_heap_priority_queue_unit.sv]
// Push: the new entry climbs from the last slot, one parent read and compare per level,
//   until its parent is not smaller or it reaches the root.
// Pop: the root is returned and the last entry sifts down, reading the left and, if present,
//   the right child through the single memory read port at each level examined.
// One transaction at a time: s_tready is high from the edge that loads the result, so a new
//   item is taken only after the last result is loaded; a stalled full output holds the core.
module binary_max_heap_priority_queue_unit #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,   // capacity_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,    // key_in[31:0], payload_in[47:32]
  input  logic [0:0]  s_tuser,    // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // key_out[31:0], payload_out[47:32], occupancy[54:48]
  output logic [1:0]  m_tuser     // status
);

  logic [hpq_pkg::LIMIT_W-1:0] limit;
  logic                        core_ready;
  logic                        core_done;
  logic                        take;
  hpq_pkg::res_t               core_res;
  hpq_pkg::res_t               out_res;
  logic                        out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= hpq_pkg::LIMIT_W'(64);
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  assign s_tready = core_ready;
  assign take     = core_done && (!out_valid || m_tready);

  hpq_core #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (s_tvalid && core_ready),
    .op     (s_tuser[0]),
    .key_in (s_tdata[31:0]),
    .tag_in (s_tdata[47:32]),
    .limit  (limit),
    .take   (take),
    .ready  (core_ready),
    .done   (core_done),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.occ, out_res.tag, out_res.key};
  assign m_tuser  = out_res.status;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int   HEAP_DEPTH = 64;
  localparam int   SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] tag;
  } heap_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;

  binary_max_heap_priority_queue_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow heap
  heap_entry_t   heap_img [HEAP_DEPTH];
  int unsigned   heap_count = 0;
  logic [6:0]    capacity_reg = 7'd64;
  hpq_pkg::res_t pending_results [$];

  int unsigned mismatches = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned pop_hits = 0;
  int unsigned full_drops = 0;
  int unsigned empty_pops = 0;
  int unsigned peak_occ = 0;

  bit          tx_bursty = 1'b0;
  bit          rx_stalls = 1'b0;
  int unsigned burst_left = 0;

  function automatic void sift_up(int unsigned pos);
    heap_entry_t moving;
    int unsigned parent;
    moving = heap_img[pos];
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_img[parent].key >= moving.key) break;
      heap_img[pos] = heap_img[parent];
      pos = parent;
    end
    heap_img[pos] = moving;
  endfunction

  function automatic void sift_down(int unsigned n);
    heap_entry_t moving;
    int unsigned pos;
    int unsigned lchild;
    int unsigned pick;
    pos = 0;
    moving = heap_img[0];
    forever begin
      lchild = 2 * pos + 1;
      pick = lchild;
      if (lchild >= n) break;
      if (lchild + 1 < n && heap_img[lchild].key < heap_img[lchild + 1].key) pick = lchild + 1;
      if (heap_img[pick].key <= moving.key) break;
      heap_img[pos] = heap_img[pick];
      pos = pick;
    end
    heap_img[pos] = moving;
  endfunction

  function automatic hpq_pkg::res_t heap_apply(logic op, logic [31:0] key, logic [15:0] tag);
    hpq_pkg::res_t r;
    int unsigned lim;
    r = '0;
    lim = (capacity_reg > HEAP_DEPTH) ? HEAP_DEPTH : capacity_reg;
    if (op == hpq_pkg::OP_PUSH) begin
      if (heap_count >= lim) begin
        r.status = hpq_pkg::ST_FULL;
      end else begin
        heap_img[heap_count] = '{key: key, tag: tag};
        sift_up(heap_count);
        heap_count++;
        r.status = hpq_pkg::ST_PUSH_OK;
      end
    end else begin
      if (heap_count == 0) begin
        r.status = hpq_pkg::ST_EMPTY;
      end else begin
        r.status = hpq_pkg::ST_POP_OK;
        r.key = heap_img[0].key;
        r.tag = heap_img[0].tag;
        heap_count--;
        if (heap_count > 0) begin
          heap_img[0] = heap_img[heap_count];
          sift_down(heap_count);
        end
      end
    end
    r.occ = heap_count[hpq_pkg::OCC_W-1:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 7);
      3: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // sender; called and returns at a falling edge
  task automatic send_item(input logic op, input logic [31:0] key, input logic [15:0] tag);
    if (tx_bursty) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 10)) @(negedge clk);
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    s_tuser = op;
    s_tdata = {tag, key};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(heap_apply(op, key, tag));
    sent_count++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] lim);
    wait_drained();
    cfg_data = lim;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    capacity_reg = lim;
  endtask

  task automatic push_pop_mix(input int unsigned n_items, input int unsigned push_pct);
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        send_item(hpq_pkg::OP_PUSH, pick_key(), 16'($urandom));
      else
        send_item(hpq_pkg::OP_POP, $urandom, 16'($urandom));
    end
  endtask

  task automatic test_empty_and_extremes();
    send_item(hpq_pkg::OP_POP, 32'h0, 16'h0);
    send_item(hpq_pkg::OP_PUSH, 32'h0, 16'h0);
    send_item(hpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(hpq_pkg::OP_PUSH, 32'h8000_0000, 16'h5AA5);
    repeat (3) send_item(hpq_pkg::OP_POP, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(hpq_pkg::OP_POP, 32'h0, 16'h0);
  endtask

  // equal keys are never swapped
  task automatic test_equal_keys();
    send_item(hpq_pkg::OP_PUSH, 32'd7, 16'd1);
    send_item(hpq_pkg::OP_PUSH, 32'd7, 16'd2);
    send_item(hpq_pkg::OP_PUSH, 32'd7, 16'd3);
    repeat (3) send_item(hpq_pkg::OP_POP, 32'h0, 16'h0);
  endtask

  task automatic test_capacity_one();
    set_capacity(7'd1);
    send_item(hpq_pkg::OP_PUSH, 32'h1234_5678, 16'hA001);
    send_item(hpq_pkg::OP_PUSH, 32'hFFFF_0000, 16'hA002);
    send_item(hpq_pkg::OP_POP, 32'h0, 16'h0);
  endtask

  task automatic test_limit_changes();
    set_capacity(7'd64);
    send_item(hpq_pkg::OP_PUSH, 32'd300, 16'd10);
    send_item(hpq_pkg::OP_PUSH, 32'd100, 16'd11);
    send_item(hpq_pkg::OP_PUSH, 32'd200, 16'd12);
    set_capacity(7'd2);
    send_item(hpq_pkg::OP_PUSH, 32'd999, 16'd13);
    set_capacity(7'd0);
    send_item(hpq_pkg::OP_POP, 32'h0, 16'h0);
    send_item(hpq_pkg::OP_PUSH, 32'd5, 16'd14);
    set_capacity(7'd2);
    send_item(hpq_pkg::OP_POP, 32'h0, 16'h0);
    send_item(hpq_pkg::OP_PUSH, 32'd150, 16'd15);
  endtask

  task automatic test_fill_to_depth();
    set_capacity(7'd127);
    tx_bursty = 1'b1;
    rx_stalls = 1'b1;
    repeat (HEAP_DEPTH - heap_count + 1) send_item(hpq_pkg::OP_PUSH, pick_key(), 16'($urandom));
    wait_drained();
    repeat (HEAP_DEPTH + 1) send_item(hpq_pkg::OP_POP, $urandom, 16'($urandom));
  endtask

  task automatic test_random_mix();
    for (int unsigned round = 0; round < 6; round++) begin
      case (round % 3)
        0: set_capacity(7'd64);
        1: set_capacity(7'($urandom_range(1, 127)));
        default: set_capacity(7'($urandom_range(2, 12)));
      endcase
      tx_bursty = round[0];
      rx_stalls = (round != 3);
      push_pop_mix(50, 75);
      push_pop_mix(35, 25);
    end
  endtask

  // receiver stall pattern, refreshed after every pass through all bits of rx_bits
  logic [31:0] rx_bits = '0;
  logic [4:0]  rx_pos = '0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
    end else begin
      if (rx_pos == 0) rx_bits = $urandom | ($urandom_range(0, 1) ? $urandom : 32'h0);
      m_tready = !rx_stalls || rx_bits[rx_pos];
      rx_pos = rx_pos + 1'b1;
    end
  end

  hpq_pkg::res_t got;
  hpq_pkg::res_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.status = hpq_pkg::status_t'(m_tuser);
      got.key = m_tdata[31:0];
      got.tag = m_tdata[47:32];
      got.occ = m_tdata[54:48];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d key %h tag %h occ %0d",
                   got.status, got.key, got.tag, got.occ);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        case (want.status)
          hpq_pkg::ST_POP_OK: pop_hits++;
          hpq_pkg::ST_FULL:   full_drops++;
          hpq_pkg::ST_EMPTY:  empty_pops++;
          default:   ;
        endcase
        if (want.occ > peak_occ) peak_occ = want.occ;
        if (got.status !== want.status || got.key !== want.key ||
            got.tag !== want.tag || got.occ !== want.occ) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d key %h/%h tag %h/%h occ %0d/%0d (exp/got)",
                     want.status, got.status, want.key, got.key,
                     want.tag, got.tag, want.occ, got.occ);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    rx_stalls = 1'b1;
    test_empty_and_extremes();
    test_equal_keys();
    test_capacity_one();
    test_limit_changes();
    test_fill_to_depth();
    test_random_mix();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) mismatches++;
    $display("Ran %0d transactions, %0d results checked: %0d pops, %0d full drops,",
             sent_count, checked_count, pop_hits, full_drops);
    $display("%0d empty pops; capacity limits 0, 1, 2, 64, 127 and random; peak %0d, %0d bad",
             empty_pops, peak_occ, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
